FILE: hdl/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/ptw_pkg.sv
package ptw_pkg;

  // default parameter values
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_LENGTH_DEF   = 65536;

  // configuration port
  localparam int unsigned APB_AW = 2;
  localparam logic [APB_AW-1:0] ADDR_FRAME_LENGTH = 2'd0;

  // frame length register
  localparam int unsigned LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;
  localparam logic [LEN_W-1:0] LEN_MIN   = 17'd3;

  // weight arithmetic
  localparam int unsigned W_W          = 17;
  localparam logic [W_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam int unsigned U_W          = 20;
  localparam int unsigned Z_W          = 36;
  localparam int          Z_LIMIT      = 12 << 16;
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned SQUARINGS    = 4;
  localparam logic [31:0] Q31_ONE      = 32'h8000_0000;

  // serial arithmetic units
  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 33;
  localparam int unsigned MUL_W  = 32;

endpackage

FILE: hdl/planck_taper_window.sv
// planck taper window, one complex sample per item
// every step runs on the bit-serial divider or the bit-serial multiplier, which
// all steps share; a new beat is taken only after the previous result has
// entered the output register
// reset: asynchronous active low; frame length 1024, sample index 0
`include "assert_macros.svh"

module planck_taper_window #(
  parameter int unsigned SAMPLE_WIDTH = ptw_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_LENGTH   = ptw_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptw_pkg::APB_AW-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_im_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      out_re_o,
  output logic signed [SAMPLE_WIDTH-1:0]      out_im_o,
  output logic [ptw_pkg::W_W-1:0]             weight_o,
  output logic                                frame_last_o
);
  import ptw_pkg::*;

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned PW  = 50;
  localparam int unsigned RW  = PW - 16;
  localparam int unsigned IXW = 21;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ZDIV = 8'b0000_0010,
    ST_TMUL = 8'b0000_0100,
    ST_TDIV = 8'b0000_1000,
    ST_SQ   = 8'b0001_0000,
    ST_WDIV = 8'b0010_0000,
    ST_SMUL = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q;
  logic   run_q;
  logic   phase_q;

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] idx_q;

  logic signed [SW-1:0] re_q, im_q, res_re_q, res_im_q;
  logic                 last_q;
  logic [18:0]          m3_q;
  logic [IXW-1:0]       p_q, qd_q;
  logic [34:0]          q1_q;
  logic                 zneg_q;
  logic [U_W-1:0]       u_q;
  logic [31:0]          term_q, t_q;
  logic [32:0]          sum_q;
  logic [3:0]           i_q;
  logic [1:0]           sq_cnt_q;
  logic [W_W-1:0]       w_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_re_q, out_im_q;
  logic [W_W-1:0]       out_w_q;
  logic                 out_last_q;

  // configuration write
  logic             cfg_wr;
  logic [LEN_W-1:0] wr_len;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_FRAME_LENGTH);
  always_comb begin
    wr_len = pwdata[LEN_W-1:0];
    if (wr_len < LEN_MIN) begin
      wr_len = LEN_MIN;
    end else if (32'(wr_len) > MAX_LENGTH) begin
      wr_len = LEN_W'(MAX_LENGTH);
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FRAME_LENGTH) ? 32'(len_q) : 32'd0;

  // sample index and edge divisors for the accepted beat
  logic             in_acc;
  logic [LEN_W-1:0] m, k, k_next;
  logic [IXW-1:0]   m3, m7, k10, mk10;
  logic             is_end, is_rise, is_flat;
  assign in_acc = in_valid_i && in_ready_o;
  always_comb begin
    m       = len_q - 1'b1;
    k       = (frame_start_i || (idx_q >= len_q)) ? '0 : idx_q;
    k_next  = ((LEN_W+1)'(k) + 1'b1 >= (LEN_W+1)'(len_q)) ? '0 : k + 1'b1;
    m3      = (IXW'(m) << 1) + IXW'(m);
    m7      = (IXW'(m) << 3) - IXW'(m);
    k10     = (IXW'(k) << 3) + (IXW'(k) << 1);
    mk10    = (IXW'(m - k) << 3) + (IXW'(m - k) << 1);
    is_end  = (k == '0) || (k == m);
    is_rise = k10 < m3;
    is_flat = k10 <= m7;
  end

  // shared serial units
  logic                 div_start, div_busy, div_done;
  logic [DIV_NW-1:0]    div_num, div_quo;
  logic [DIV_DW-1:0]    div_den;
  logic                 mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_prod;

  logic [DIV_DW-1:0]    wden;
  logic signed [32:0]   s_ext;
  logic [MUL_W-1:0]     s_mag;

  always_comb begin
    wden  = {1'b0, Q31_ONE} + {1'b0, sum_q[31:0]};
    s_ext = phase_q ? 33'(im_q) : 33'(re_q);
    s_mag = 32'((s_ext < 0) ? -s_ext : s_ext);
    div_num = {13'd0, m3_q, 16'd0};
    div_den = DIV_DW'(phase_q ? qd_q : p_q);
    mul_a   = term_q;
    mul_b   = MUL_W'(u_q);
    case (state_q)
      ST_TDIV: begin
        div_num = DIV_NW'(t_q);
        div_den = DIV_DW'(i_q);
      end
      ST_WDIV: begin
        div_num = (zneg_q ? {Q31_ONE, 16'd0} : {sum_q[31:0], 16'd0}) + DIV_NW'(wden >> 1);
        div_den = wden;
      end
      default: begin
      end
    endcase
    case (state_q)
      ST_SQ: begin
        mul_a = sum_q[31:0];
        mul_b = sum_q[31:0];
      end
      ST_SMUL: begin
        mul_a = s_mag;
        mul_b = MUL_W'(w_q);
      end
      default: begin
      end
    endcase
  end

  assign div_start = !run_q && ((state_q == ST_ZDIV) || (state_q == ST_TDIV) ||
                                (state_q == ST_WDIV));
  assign mul_start = !run_q && ((state_q == ST_TMUL) || (state_q == ST_SQ) ||
                                (state_q == ST_SMUL));

  ptw_div_serial #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  ptw_mul_serial #(.W(MUL_W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // edge value from the two quotients
  logic signed [Z_W-1:0] z;
  logic [Z_W-1:0]        z_abs;
  assign z     = $signed({1'b0, q1_q}) - $signed({1'b0, div_quo[34:0]});
  assign z_abs = (z < 0) ? -z : z;

  // rounded, saturated product of sample and weight
  logic signed [PW-1:0] prod_s;
  logic signed [RW-1:0] rnd, sat_hi, sat_lo;
  logic signed [SW-1:0] scaled;
  always_comb begin
    prod_s = (s_ext < 0) ? -$signed(mul_prod[PW-1:0]) : $signed(mul_prod[PW-1:0]);
    rnd    = RW'((prod_s + PW'(32768)) >>> 16);
    sat_hi = (RW'(1) <<< (SW - 1)) - RW'(1);
    sat_lo = -sat_hi - RW'(1);
    if (rnd > sat_hi) begin
      scaled = SW'(sat_hi);
    end else if (rnd < sat_lo) begin
      scaled = SW'(sat_lo);
    end else begin
      scaled = SW'(rnd);
    end
  end

  // control: sequencer, frame length, index, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      phase_q     <= 1'b0;
      len_q       <= LEN_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        len_q <= wr_len;
      end
      if (div_start || mul_start) begin
        run_q <= 1'b1;
      end else if (div_done || mul_done) begin
        run_q <= 1'b0;
      end
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q   <= k_next;
            phase_q <= 1'b0;
            state_q <= (is_end || (!is_rise && is_flat)) ? ST_SMUL : ST_ZDIV;
          end
        end
        ST_ZDIV: begin
          if (div_done) begin
            phase_q <= !phase_q;
            if (phase_q) begin
              if ((z >= Z_W'(Z_LIMIT)) || (z <= -Z_W'(Z_LIMIT))) begin
                state_q <= ST_SMUL;
              end else begin
                state_q <= ST_TMUL;
              end
            end
          end
        end
        ST_TMUL: begin
          if (mul_done) begin
            state_q <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            state_q <= (i_q == 4'(TAYLOR_TERMS)) ? ST_SQ : ST_TMUL;
          end
        end
        ST_SQ: begin
          if (mul_done && (sq_cnt_q == 2'(SQUARINGS - 1))) begin
            state_q <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            state_q <= ST_SMUL;
          end
        end
        ST_SMUL: begin
          if (mul_done) begin
            phase_q <= !phase_q;
            if (phase_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          re_q   <= sample_re_i;
          im_q   <= sample_im_i;
          last_q <= (k == m);
          m3_q   <= m3[18:0];
          p_q    <= is_rise ? k10 : mk10;
          qd_q   <= is_rise ? (m3 - k10) : (k10 - m7);
          w_q    <= is_end ? '0 : WEIGHT_ONE;
        end
      end
      ST_ZDIV: begin
        if (div_done) begin
          if (!phase_q) begin
            q1_q <= div_quo[34:0];
          end else begin
            zneg_q <= z < 0;
            u_q    <= z_abs[U_W-1:0];
            term_q <= Q31_ONE;
            sum_q  <= {1'b0, Q31_ONE};
            i_q    <= 4'd1;
            if (z >= Z_W'(Z_LIMIT)) begin
              w_q <= '0;
            end else if (z <= -Z_W'(Z_LIMIT)) begin
              w_q <= WEIGHT_ONE;
            end
          end
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          t_q <= mul_prod[51:20];
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          term_q   <= div_quo[31:0];
          sum_q    <= i_q[0] ? (sum_q - {1'b0, div_quo[31:0]}) :
                               (sum_q + {1'b0, div_quo[31:0]});
          i_q      <= i_q + 1'b1;
          sq_cnt_q <= '0;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          sum_q    <= {1'b0, mul_prod[62:31]};
          sq_cnt_q <= sq_cnt_q + 1'b1;
        end
      end
      ST_WDIV: begin
        if (div_done) begin
          w_q <= div_quo[W_W-1:0];
        end
      end
      ST_SMUL: begin
        if (mul_done) begin
          if (phase_q) begin
            res_im_q <= scaled;
          end else begin
            res_re_q <= scaled;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_re_q   <= res_re_q;
          out_im_q   <= res_im_q;
          out_w_q    <= w_q;
          out_last_q <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign out_re_o     = out_re_q;
  assign out_im_o     = out_im_q;
  assign weight_o     = out_w_q;
  assign frame_last_o = out_last_q;

  // checks
  `ASSERT_CLK(len_range_a, (len_q >= LEN_MIN) && (32'(len_q) <= MAX_LENGTH), "frame length out of range")
  `ASSERT_IMPL(weight_max_a, out_valid_q, out_w_q <= WEIGHT_ONE, "weight above one")
  `ASSERT_IMPL(idle_units_a, state_q == ST_IDLE, !div_busy && !mul_busy, "unit busy while idle")

endmodule

FILE: hdl/ptw_div_serial.sv
module ptw_div_serial #(
  parameter int unsigned NW = ptw_pkg::DIV_NW,
  parameter int unsigned DW = ptw_pkg::DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  import ptw_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   rem_d;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial = {rem_q[DW-1:0], quo_q[NW-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? (trial - {1'b0, den_q}) : trial;
  end

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/ptw_mul_serial.sv
module ptw_mul_serial #(
  parameter int unsigned W = ptw_pkg::MUL_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);
  import ptw_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] acc_q;
  logic [W-1:0]   a_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [W:0]     sum;

  // shift-add on the low multiplier bit
  assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, a_q} : '0);

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // product shift register, multiplier enters at the low end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{W{1'b0}}, b_i};
      a_q   <= a_i;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
